>>> rtl/pulsed_ir_ambient_cancel_sequencer_macros.svh
// assertion macros shared by the sequencer checker
`ifndef PULSED_IR_AMBIENT_CANCEL_SEQUENCER_MACROS_SVH
`define PULSED_IR_AMBIENT_CANCEL_SEQUENCER_MACROS_SVH

// same-cycle implication, off during reset
`define PIRACS_AST_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off during reset
`define PIRACS_AST_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// checked through reset: a condition that must hold on the edge after reset
`define PIRACS_AST_RST(label, clk, rst_n, cons) \
    label: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
        else $error("reset check failed");

`endif

>>> rtl/piracs_pkg.sv
// ----------------------------------------------------------------------------
// piracs_pkg
// types, constants and the divide-by-ten helper of the ir ambient sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package piracs_pkg;

    localparam int ADC_BITS      = 12;
    localparam int CHANNELS      = 4;
    localparam int TICK_BITS     = 10;
    localparam int PW_BITS       = 8;
    localparam int LEVEL_BITS    = 9;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 10;

    // channel slots
    localparam int CH_FRONT_LEFT  = 0;
    localparam int CH_FRONT_RIGHT = 1;
    localparam int CH_LEFT_DIAG   = 2;
    localparam int CH_RIGHT_DIAG  = 3;

    // register reset values
    localparam logic [PW_BITS-1:0]   PULSE_WIDTH_RST       = 8'd50;
    localparam logic [TICK_BITS-1:0] FRONT_RIGHT_START_RST = 10'd150;
    localparam logic [TICK_BITS-1:0] LEFT_DIAG_START_RST   = 10'd300;
    localparam logic [TICK_BITS-1:0] RIGHT_DIAG_START_RST  = 10'd400;
    localparam logic [TICK_BITS-1:0] CYCLE_END_RST         = 10'd500;

    // x / 10 == (x * 52429) >> 19 for every x below 2**16
    localparam int DIV10_MUL   = 52429;
    localparam int DIV10_SHIFT = 19;
    localparam int PROD_BITS   = ADC_BITS + 17;
    localparam int LEVEL_MAX   = 511;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PULSE_WIDTH       = 3'd0,
        CFG_FRONT_RIGHT_START = 3'd1,
        CFG_LEFT_DIAG_START   = 3'd2,
        CFG_RIGHT_DIAG_START  = 3'd3,
        CFG_CYCLE_END         = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_START = 1'b1
    } t_cmd;

    typedef struct packed {
        logic                cmd;
        logic [ADC_BITS-1:0] adc_front_left;
        logic [ADC_BITS-1:0] adc_front_right;
        logic [ADC_BITS-1:0] adc_left_diag;
        logic [ADC_BITS-1:0] adc_right_diag;
    } t_in_req;

    typedef struct packed {
        logic                  front_emitter_on;
        logic                  left_diag_emitter_on;
        logic                  right_diag_emitter_on;
        logic                  busy_res;
        logic                  done_res;
        logic [LEVEL_BITS-1:0] level_front_left;
        logic [LEVEL_BITS-1:0] level_front_right;
        logic [LEVEL_BITS-1:0] level_left_diag;
        logic [LEVEL_BITS-1:0] level_right_diag;
    } t_out_res;

    // truncating divide by ten, saturated to the level width
    function automatic logic [LEVEL_BITS-1:0] f_level(input logic [ADC_BITS-1:0] diff);
        logic [PROD_BITS-1:0] prod;
        logic [PROD_BITS-1:0] quot;
        prod = PROD_BITS'(diff) * PROD_BITS'(DIV10_MUL);
        quot = prod >> DIV10_SHIFT;
        if (quot > PROD_BITS'(LEVEL_MAX)) begin
            f_level = LEVEL_BITS'(LEVEL_MAX);
        end else begin
            f_level = quot[LEVEL_BITS-1:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/pulsed_ir_ambient_cancel_sequencer.sv
// ----------------------------------------------------------------------------
// pulsed_ir_ambient_cancel_sequencer
// timed ir receiver front end with ambient light subtraction
// ----------------------------------------------------------------------------
// Each request on the input channel is either a start (latch the four ambient
// adc readings, clear the counter) or a microsecond tick (advance the counter,
// drive the emitters, sample a channel when its pulse ends, finish the cycle at
// cycle_end). Every request yields exactly one result in the cycle after it is
// taken: emitter drives, busy, done and the levels of the last finished cycle.
// One request is taken per clock; the whole update is a single pass from the
// request and the sequencer state into the result register, so the only thing
// that stops intake is a held result that the consumer has not yet taken.
// Configuration writes are registered and must only happen while idle.
`timescale 1ns / 1ps
`default_nettype none

module pulsed_ir_ambient_cancel_sequencer (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // request channel
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire piracs_pkg::t_in_req             i_in,
    // result channel
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output piracs_pkg::t_out_res                 o_out,
    // configuration write port
    input  wire                                  i_cfg_we,
    input  wire [piracs_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire [piracs_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int NCH = piracs_pkg::CHANNELS;
    localparam int TB  = piracs_pkg::TICK_BITS;
    localparam int AB  = piracs_pkg::ADC_BITS;
    localparam int LB  = piracs_pkg::LEVEL_BITS;

    // configuration registers
    logic [piracs_pkg::PW_BITS-1:0] r_pulse_width;
    logic [TB-1:0]                  r_front_right_start;
    logic [TB-1:0]                  r_left_diag_start;
    logic [TB-1:0]                  r_right_diag_start;
    logic [TB-1:0]                  r_cycle_end;

    // sequencer state
    logic [AB-1:0] r_ambient [NCH];
    logic [AB-1:0] r_lit     [NCH];
    logic [LB-1:0] r_final   [NCH];
    logic [TB-1:0] r_tick;
    logic          r_running;

    logic [AB-1:0] n_ambient [NCH];
    logic [AB-1:0] n_lit     [NCH];
    logic [LB-1:0] n_final   [NCH];
    logic [TB-1:0] n_tick;
    logic          n_running;

    // result register
    logic                 r_out_valid;
    piracs_pkg::t_out_res r_out;
    piracs_pkg::t_out_res n_out;

    logic          w_accept;
    logic          w_start;
    logic          w_step;
    logic          w_end;
    logic [TB-1:0] w_tick_inc;
    logic [TB-1:0] w_slot [NCH];
    logic [AB-1:0] w_adc  [NCH];
    logic [NCH-1:0] w_lit_on;

    // a held result that is not being taken blocks the next request
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_slot[piracs_pkg::CH_FRONT_LEFT]  = '0;
    assign w_slot[piracs_pkg::CH_FRONT_RIGHT] = r_front_right_start;
    assign w_slot[piracs_pkg::CH_LEFT_DIAG]   = r_left_diag_start;
    assign w_slot[piracs_pkg::CH_RIGHT_DIAG]  = r_right_diag_start;

    assign w_adc[piracs_pkg::CH_FRONT_LEFT]  = i_in.adc_front_left;
    assign w_adc[piracs_pkg::CH_FRONT_RIGHT] = i_in.adc_front_right;
    assign w_adc[piracs_pkg::CH_LEFT_DIAG]   = i_in.adc_left_diag;
    assign w_adc[piracs_pkg::CH_RIGHT_DIAG]  = i_in.adc_right_diag;

    // start while running is dropped; tick while idle does nothing
    assign w_start    = (i_in.cmd == piracs_pkg::CMD_START) && !r_running;
    assign w_step     = (i_in.cmd == piracs_pkg::CMD_TICK) && r_running;
    assign w_tick_inc = r_tick + TB'(1);
    assign w_end      = w_step && (w_tick_inc == r_cycle_end);

    always_comb begin
        n_tick    = r_tick;
        n_running = r_running;
        if (w_start) begin
            n_tick    = '0;
            n_running = 1'b1;
        end else if (w_step) begin
            n_tick = w_tick_inc;
            if (w_end) begin
                n_running = 1'b0;
            end
        end

        for (int i = 0; i < NCH; i++) begin
            n_ambient[i] = r_ambient[i];
            n_lit[i]     = r_lit[i];
            n_final[i]   = r_final[i];
            if (w_start) begin
                n_ambient[i] = w_adc[i];
                n_lit[i]     = '0;
            end else if (w_step) begin
                // sample when the counter reaches the end of this slot's pulse;
                // a pulse end past the counter range never matches
                if ((TB+1)'(w_tick_inc) ==
                    (TB+1)'(w_slot[i]) + (TB+1)'(r_pulse_width)) begin
                    n_lit[i] = (w_adc[i] > r_ambient[i]) ? w_adc[i] - r_ambient[i] : '0;
                end
            end
            // sample goes first, then the end of cycle scales it
            if (w_end) begin
                n_final[i] = piracs_pkg::f_level(n_lit[i]);
            end
            // emitter window after the update
            w_lit_on[i] = n_running && (n_tick >= w_slot[i]) &&
                          ((TB+1)'(n_tick) < (TB+1)'(w_slot[i]) + (TB+1)'(r_pulse_width));
        end

        n_out.front_emitter_on      = w_lit_on[piracs_pkg::CH_FRONT_LEFT] ||
                                      w_lit_on[piracs_pkg::CH_FRONT_RIGHT];
        n_out.left_diag_emitter_on  = w_lit_on[piracs_pkg::CH_LEFT_DIAG];
        n_out.right_diag_emitter_on = w_lit_on[piracs_pkg::CH_RIGHT_DIAG];
        n_out.busy_res              = n_running;
        n_out.done_res              = w_end;
        n_out.level_front_left      = n_final[piracs_pkg::CH_FRONT_LEFT];
        n_out.level_front_right     = n_final[piracs_pkg::CH_FRONT_RIGHT];
        n_out.level_left_diag       = n_final[piracs_pkg::CH_LEFT_DIAG];
        n_out.level_right_diag      = n_final[piracs_pkg::CH_RIGHT_DIAG];
    end

    // configuration writes, unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_width       <= piracs_pkg::PULSE_WIDTH_RST;
            r_front_right_start <= piracs_pkg::FRONT_RIGHT_START_RST;
            r_left_diag_start   <= piracs_pkg::LEFT_DIAG_START_RST;
            r_right_diag_start  <= piracs_pkg::RIGHT_DIAG_START_RST;
            r_cycle_end         <= piracs_pkg::CYCLE_END_RST;
        end else if (i_cfg_we) begin
            case (piracs_pkg::t_cfg_idx'(i_cfg_index))
                piracs_pkg::CFG_PULSE_WIDTH: begin
                    r_pulse_width <= i_cfg_data[piracs_pkg::PW_BITS-1:0];
                end
                piracs_pkg::CFG_FRONT_RIGHT_START: begin
                    r_front_right_start <= i_cfg_data[TB-1:0];
                end
                piracs_pkg::CFG_LEFT_DIAG_START: begin
                    r_left_diag_start <= i_cfg_data[TB-1:0];
                end
                piracs_pkg::CFG_RIGHT_DIAG_START: begin
                    r_right_diag_start <= i_cfg_data[TB-1:0];
                end
                piracs_pkg::CFG_CYCLE_END: begin
                    r_cycle_end <= i_cfg_data[TB-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // sequencer state advances once per accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick    <= '0;
            r_running <= 1'b0;
            for (int i = 0; i < NCH; i++) begin
                r_ambient[i] <= '0;
                r_lit[i]     <= '0;
                r_final[i]   <= '0;
            end
        end else if (w_accept) begin
            r_tick    <= n_tick;
            r_running <= n_running;
            for (int i = 0; i < NCH; i++) begin
                r_ambient[i] <= n_ambient[i];
                r_lit[i]     <= n_lit[i];
                r_final[i]   <= n_final[i];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

>>> rtl/piracs_checker.sv
// ----------------------------------------------------------------------------
// piracs_checker
// port-level checks of the ir ambient sequencer, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "pulsed_ir_ambient_cancel_sequencer_macros.svh"

module piracs_checker (
    input wire                       i_clk,
    input wire                       i_rst_n,
    input wire                       i_out_ready,
    input wire                       o_out_valid,
    input wire piracs_pkg::t_out_res o_out
);

    logic w_any_emitter;
    logic w_stall;

    assign w_any_emitter = o_out.front_emitter_on || o_out.left_diag_emitter_on ||
                           o_out.right_diag_emitter_on;
    assign w_stall       = o_out_valid && !i_out_ready;

    // the finishing tick leaves the sequencer idle
    `PIRACS_AST_IMP(a_done_idle, i_clk, i_rst_n, o_out_valid && o_out.done_res, !o_out.busy_res)

    // no emitter lit outside a cycle
    `PIRACS_AST_IMP(a_idle_dark, i_clk, i_rst_n, o_out_valid && !o_out.busy_res, !w_any_emitter)

    // a stalled result holds
    `PIRACS_AST_NXT(a_hold, i_clk, i_rst_n, w_stall, o_out_valid && $stable(o_out))

    // nothing offered right after reset
    `PIRACS_AST_RST(a_rst_empty, i_clk, i_rst_n, !o_out_valid)

endmodule

bind pulsed_ir_ambient_cancel_sequencer piracs_checker u_piracs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_ready (i_out_ready),
    .o_out_valid (o_out_valid),
    .o_out       (o_out)
);

`default_nettype wire

>>> tb/tb_pulsed_ir_ambient_cancel_sequencer.sv
// ----------------------------------------------------------------------------
// tb_pulsed_ir_ambient_cancel_sequencer
// self-checking bench for the pulsed ir ambient-cancel sequencer
// ----------------------------------------------------------------------------
// Drives start and tick requests through the valid/ready request channel and
// checks every result against a cycle-accurate predictor kept in a small
// scoreboard class. A short directed part hits field extremes, clamping,
// starts while busy, ticks while idle, sample-on-cycle-end and an unknown
// register index. Random schedules follow, including the reset schedule and
// a counter wraparound cycle, with random idling on both channels, a long
// consumer hold-off and a sender pause until the pipe drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pulsed_ir_ambient_cancel_sequencer;

    import piracs_pkg::*;

    // register index that decodes to nothing, the write must be dropped
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_UNUSED = 3'd7;
    localparam int TARGET_ITEMS = 1850;
    localparam int HOLD_CYCLES  = 60;
    localparam int IDLE_PCT     = 8;

    // ------------------------------------------------------------------------
    // predictor and result store
    // ------------------------------------------------------------------------
    class ambient_cancel_scoreboard;
        // schedule registers
        logic [PW_BITS-1:0]    pulse_width;
        logic [TICK_BITS-1:0]  fr_start;
        logic [TICK_BITS-1:0]  ld_start;
        logic [TICK_BITS-1:0]  rd_start;
        logic [TICK_BITS-1:0]  cycle_end;
        // sequencer state
        logic [ADC_BITS-1:0]   ambient[CHANNELS];
        logic [ADC_BITS-1:0]   lit_diff[CHANNELS];
        logic [LEVEL_BITS-1:0] level[CHANNELS];
        logic [TICK_BITS-1:0]  tick;
        bit                    running;
        // expected sensor outputs, oldest first
        t_out_res              sensor_out_q[$];
        int                    errors;
        int                    results_seen;
        int                    cycles_done;

        function new();
            pulse_width = PULSE_WIDTH_RST;
            fr_start    = FRONT_RIGHT_START_RST;
            ld_start    = LEFT_DIAG_START_RST;
            rd_start    = RIGHT_DIAG_START_RST;
            cycle_end   = CYCLE_END_RST;
            for (int ch = 0; ch < CHANNELS; ch++) begin
                ambient[ch]  = '0;
                lit_diff[ch] = '0;
                level[ch]    = '0;
            end
            tick         = '0;
            running      = 1'b0;
            errors       = 0;
            results_seen = 0;
            cycles_done  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_PULSE_WIDTH:       pulse_width = data[PW_BITS-1:0];
                CFG_FRONT_RIGHT_START: fr_start    = data;
                CFG_LEFT_DIAG_START:   ld_start    = data;
                CFG_RIGHT_DIAG_START:  rd_start    = data;
                CFG_CYCLE_END:         cycle_end   = data;
                default: ;
            endcase
        endfunction

        function int slot_start(int ch);
            case (ch)
                CH_FRONT_RIGHT: return int'(fr_start);
                CH_LEFT_DIAG:   return int'(ld_start);
                CH_RIGHT_DIAG:  return int'(rd_start);
                default:        return 0;
            endcase
        endfunction

        // sums are taken without wrap, so a slot ending past 1023 never samples
        function bit slot_lit(int ch);
            int s;
            s = slot_start(ch);
            return running && int'(tick) >= s && int'(tick) < s + int'(pulse_width);
        endfunction

        function void note_request(t_in_req r);
            logic [ADC_BITS-1:0] adc[CHANNELS];
            t_out_res            res;
            bit                  cycle_done;
            int                  quot;
            adc[CH_FRONT_LEFT]  = r.adc_front_left;
            adc[CH_FRONT_RIGHT] = r.adc_front_right;
            adc[CH_LEFT_DIAG]   = r.adc_left_diag;
            adc[CH_RIGHT_DIAG]  = r.adc_right_diag;
            cycle_done = 1'b0;
            if (r.cmd == CMD_START) begin
                if (!running) begin
                    for (int ch = 0; ch < CHANNELS; ch++) begin
                        ambient[ch]  = adc[ch];
                        lit_diff[ch] = '0;
                    end
                    tick    = '0;
                    running = 1'b1;
                end
            end else if (running) begin
                tick = tick + 1'b1;
                // sample before the cycle-end check
                for (int ch = 0; ch < CHANNELS; ch++) begin
                    if (int'(tick) == slot_start(ch) + int'(pulse_width)) begin
                        lit_diff[ch] = (adc[ch] > ambient[ch]) ? adc[ch] - ambient[ch] : '0;
                    end
                end
                if (tick == cycle_end) begin
                    for (int ch = 0; ch < CHANNELS; ch++) begin
                        quot = int'(lit_diff[ch]) / 10;
                        level[ch] = (quot > LEVEL_MAX) ? LEVEL_BITS'(LEVEL_MAX)
                                                       : LEVEL_BITS'(quot);
                    end
                    running    = 1'b0;
                    cycle_done = 1'b1;
                    cycles_done++;
                end
            end
            res.front_emitter_on      = slot_lit(CH_FRONT_LEFT) | slot_lit(CH_FRONT_RIGHT);
            res.left_diag_emitter_on  = slot_lit(CH_LEFT_DIAG);
            res.right_diag_emitter_on = slot_lit(CH_RIGHT_DIAG);
            res.busy_res              = running;
            res.done_res              = cycle_done;
            res.level_front_left      = level[CH_FRONT_LEFT];
            res.level_front_right     = level[CH_FRONT_RIGHT];
            res.level_left_diag       = level[CH_LEFT_DIAG];
            res.level_right_diag      = level[CH_RIGHT_DIAG];
            sensor_out_q.push_back(res);
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_out_res got);
            t_out_res want;
            if (sensor_out_q.size() == 0) begin
                $error("result with no request waiting: %p", got);
                errors++;
                return;
            end
            want = sensor_out_q.pop_front();
            results_seen++;
            check_field("front_emitter_on", want.front_emitter_on, got.front_emitter_on);
            check_field("left_diag_emitter_on", want.left_diag_emitter_on,
                        got.left_diag_emitter_on);
            check_field("right_diag_emitter_on", want.right_diag_emitter_on,
                        got.right_diag_emitter_on);
            check_field("busy_res", want.busy_res, got.busy_res);
            check_field("done_res", want.done_res, got.done_res);
            check_field("level_front_left", want.level_front_left, got.level_front_left);
            check_field("level_front_right", want.level_front_right, got.level_front_right);
            check_field("level_left_diag", want.level_left_diag, got.level_left_diag);
            check_field("level_right_diag", want.level_right_diag, got.level_right_diag);
        endfunction

        function int pending();
            return sensor_out_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals, every input known from time zero
    // ------------------------------------------------------------------------
    logic                     i_clk     = 1'b0;
    logic                     i_rst_n   = 1'b0;
    logic                     in_valid  = 1'b0;
    t_in_req                  in_req    = '0;
    logic                     out_ready = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
    logic                     o_in_ready;
    logic                     o_out_valid;
    t_out_res                 o_out;

    ambient_cancel_scoreboard sb = new();

    // flags shared between the stimulus and the consumer process, and the item count
    bit quiet    = 1'b0;    // no idling on either side
    bit hold_req = 1'b0;    // ask the consumer for a long hold-off
    int useful_items = 0;   // starts and ticks that move a cycle along

    pulsed_ir_ambient_cancel_sequencer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // monitor: both handshakes sampled on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && o_in_ready) begin
                sb.note_request(in_req);
            end
            if (o_out_valid && out_ready) begin
                sb.check_result(o_out);
            end
        end
    end

    // consumer: random stalls, a counted long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end else if (quiet) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------
    // offer one request and hold it until taken; valid stays high on return so
    // a back-to-back request only swaps the payload at the next falling edge
    task automatic send_req(input t_in_req r);
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // drop valid before anything that lets clocks pass without a request
    task automatic stop_requests();
        @(negedge i_clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        stop_requests();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // reprogram the whole slot schedule once the sequencer is idle and drained
    task automatic load_schedule(input logic [PW_BITS-1:0] pw, input logic [TICK_BITS-1:0] fr,
                                 input logic [TICK_BITS-1:0] ld, input logic [TICK_BITS-1:0] rd,
                                 input logic [TICK_BITS-1:0] ce);
        wait_drained();
        repeat (2) @(posedge i_clk);
        write_reg(CFG_PULSE_WIDTH, CFG_DATA_BITS'(pw));
        write_reg(CFG_FRONT_RIGHT_START, fr);
        write_reg(CFG_LEFT_DIAG_START, ld);
        write_reg(CFG_RIGHT_DIAG_START, rd);
        write_reg(CFG_CYCLE_END, ce);
    endtask

    // adc value with the rails showing up often
    function automatic logic [ADC_BITS-1:0] rand_adc();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return ADC_BITS'($urandom);
        endcase
    endfunction

    function automatic t_in_req rand_req(input t_cmd cmd);
        t_in_req r;
        r.cmd             = cmd;
        r.adc_front_left  = rand_adc();
        r.adc_front_right = rand_adc();
        r.adc_left_diag   = rand_adc();
        r.adc_right_diag  = rand_adc();
        return r;
    endfunction

    // one full measurement: a start, then ticks up to cycle_end (1024 when it
    // is zero, the counter has to wrap), with ignored starts mixed in
    task automatic run_cycle(input int noise_pct, input int pause_at, input int hold_at);
        int n_ticks;
        n_ticks = (sb.cycle_end == '0) ? 1024 : int'(sb.cycle_end);
        send_req(rand_req(CMD_START));
        useful_items++;
        for (int t = 1; t <= n_ticks; t++) begin
            if ($urandom_range(99) < noise_pct) begin
                send_req(rand_req(CMD_START));
            end
            if (t == hold_at || $urandom_range(299) == 0) begin
                hold_req = 1'b1;
            end
            if (t == pause_at || $urandom_range(199) == 0) begin
                wait_drained();
            end
            send_req(rand_req(CMD_TICK));
            useful_items++;
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int n_cycles;
        logic [PW_BITS-1:0]   pw;
        logic [TICK_BITS-1:0] fr, ld, rd, ce;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ticks while idle, all-ones and all-zeros readings
        send_req('{CMD_TICK, 12'hFFF, 12'h000, 12'hFFF, 12'h000});
        send_req('{CMD_TICK, 12'h000, 12'hFFF, 12'h000, 12'hFFF});

        // tight schedule: adjacent front slots, diagonal slots overlapping,
        // right diagonal sampled on the cycle-end tick
        load_schedule(8'd2, 10'd2, 10'd4, 10'd5, 10'd7);
        // ambient: zero, full scale, mid, tiny
        send_req('{CMD_START, 12'd0, 12'hFFF, 12'd100, 12'd5});
        for (int t = 1; t <= 7; t++) begin
            // lit readings: front-right and left diagonal fall below ambient
            send_req('{CMD_TICK, 12'hFFF, 12'd0, 12'd50, 12'hFFF});
            if (t == 3) begin
                // start while busy must change nothing
                send_req('{CMD_START, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF});
            end
        end
        send_req('{CMD_TICK, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF});

        // write to an index that decodes to nothing
        wait_drained();
        write_reg(CFG_IDX_UNUSED, 10'h3FF);

        // register extremes, one-tick cycle: front and left diagonal lit on the
        // start step, nothing sampled
        load_schedule(8'd255, 10'd1023, 10'd0, 10'd1023, 10'd1);
        send_req('{CMD_START, 12'h5A5, 12'hA5A, 12'h000, 12'hFFF});
        send_req('{CMD_TICK, 12'hA5A, 12'h5A5, 12'hFFF, 12'h000});
        send_req('{CMD_START, 12'h001, 12'h800, 12'h7FF, 12'hFFE});
        send_req('{CMD_TICK, 12'hFFE, 12'h7FF, 12'h800, 12'h001});

        // reset schedule, no random idling, a sender pause and a long
        // consumer hold-off while requests keep coming
        load_schedule(PULSE_WIDTH_RST, FRONT_RIGHT_START_RST, LEFT_DIAG_START_RST,
                      RIGHT_DIAG_START_RST, CYCLE_END_RST);
        quiet = 1'b1;
        run_cycle(2, 100, 250);
        quiet = 1'b0;

        // counter wraparound: cycle ends at tick zero, left diagonal sampled at
        // tick 1023, front-right and right diagonal end past the counter range
        load_schedule(8'd255, 10'd1023, 10'd768, 10'd1000, 10'd0);
        run_cycle(1, -1, 600);

        // random schedules, mostly short so many cycles complete
        while (useful_items < TARGET_ITEMS) begin
            pw = ($urandom_range(3) == 0) ? PW_BITS'($urandom_range(1, 255))
                                          : PW_BITS'($urandom_range(1, 6));
            fr = ($urandom_range(7) == 0) ? TICK_BITS'($urandom) : TICK_BITS'($urandom_range(0, 30));
            ld = ($urandom_range(7) == 0) ? TICK_BITS'($urandom) : TICK_BITS'($urandom_range(0, 30));
            rd = ($urandom_range(7) == 0) ? TICK_BITS'($urandom) : TICK_BITS'($urandom_range(0, 30));
            ce = TICK_BITS'($urandom_range(1, 48));
            load_schedule(pw, fr, ld, rd, ce);
            n_cycles = $urandom_range(1, 4);
            for (int c = 0; c < n_cycles; c++) begin
                repeat ($urandom_range(0, 2)) send_req(rand_req(CMD_TICK));
                run_cycle(5, -1, -1);
            end
        end

        wait_drained();
        repeat (5) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        $display("covered %0d cycle requests and %0d checked results over %0d measurement cycles",
                 useful_items, sb.results_seen, sb.cycles_done);
        $display("schedules ran from one-tick cycles to a full counter wrap");
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // run limit, far above the slowest legal run
    initial begin
        #3_000_000;
        $display("timeout with %0d results still expected", sb.pending());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> pulsed_ir_ambient_cancel_sequencer.f
+incdir+rtl
rtl/piracs_pkg.sv
rtl/pulsed_ir_ambient_cancel_sequencer.sv
rtl/piracs_checker.sv
tb/tb_pulsed_ir_ambient_cancel_sequencer.sv
